FILE: sv/fnv1a_linear_probe_hash_table_assert.svh
// Assertion macros used by the checker file of the hash table.
`ifndef FNV1A_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define FNV1A_LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLPH_ASSERT_IMP(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("flph: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define FLPH_ASSERT_NXT(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("flph: next-cycle property violated");

`endif

FILE: sv/flph_pkg.sv
`default_nettype none
package flph_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int VALUE_BITS_DEF  = 16;

	localparam int KEY_FIELD_BITS = 64;
	localparam int HANDLER_BITS   = 16;
	localparam int STATUS_BITS    = 3;
	localparam int HASH_BITS      = 32;

	localparam logic [HASH_BITS-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_BITS-1:0] FNV_PRIME = 32'd16777619;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_UPDATED  = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_NULL     = 3'd5;

	typedef struct packed {
		logic                      req_type;
		logic [KEY_FIELD_BITS-1:0] key_bytes;
		logic [HANDLER_BITS-1:0]   handler_id;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic [HANDLER_BITS-1:0] handler_out;
		logic [STATUS_BITS-1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic                   clr;
		logic                   load;
		logic                   hash_step;
		logic                   red_load;
		logic                   red_step;
		logic                   advance;
		logic                   wr;
		logic                   rsp;
		logic [STATUS_BITS-1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic null_req;
		logic is_ins;
		logic hash_end;
		logic red_done;
		logic used;
		logic match;
		logic probe_last;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: sv/flph_ram.sv
`default_nettype none
module flph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/flph_ctrl.sv
`default_nettype none
module flph_ctrl
	import flph_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_HASH   = 3'd2;
	localparam logic [2:0] S_REDUCE = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_CHECK  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (sts.null_req) begin
						cmd.rsp  = 1'b1;
						cmd.code = ST_NULL;
					end else begin
						state_d = S_HASH;
					end
				end
			end
			S_HASH: begin
				if (sts.hash_end) begin
					cmd.red_load = 1'b1;
					state_d      = S_REDUCE;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			S_REDUCE: begin
				if (sts.red_done) begin
					state_d = S_READ;
				end else begin
					cmd.red_step = 1'b1;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.used) begin
					cmd.rsp = 1'b1;
					cmd.wr  = sts.is_ins;
					cmd.code = sts.is_ins ? ST_INSERTED : ST_MISS;
					state_d = S_IDLE;
				end else if (sts.match) begin
					cmd.rsp = 1'b1;
					cmd.wr  = sts.is_ins;
					cmd.code = sts.is_ins ? ST_UPDATED : ST_HIT;
					state_d = S_IDLE;
				end else if (sts.probe_last) begin
					cmd.rsp = 1'b1;
					cmd.code = sts.is_ins ? ST_FULL : ST_MISS;
					state_d = S_IDLE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/flph_dp.sv
`default_nettype none
module flph_dp
	import flph_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BYTES   = KEY_BYTES_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire req_t    req,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	output rsp_t         rsp,
	output logic         done
);

	localparam int  IW      = $clog2(TABLE_DEPTH);
	localparam int  KW      = 8 * KEY_BYTES;
	localparam int  VW      = (VALUE_BITS < HANDLER_BITS) ? VALUE_BITS : HANDLER_BITS;
	localparam int  WW      = 1 + KW + VW;
	localparam int  RCW     = 2;
	localparam bit  IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);
	localparam logic [IW-1:0] DEPTH_LO  = IW'(TABLE_DEPTH);
	localparam logic [63:0]   RECIP_FULL =
		((64'd1 << (HASH_BITS + IW)) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
	localparam logic [HASH_BITS:0] RECIP = RECIP_FULL[HASH_BITS:0];

	logic [KW-1:0]        nk_d;
	logic [KW-1:0]        nk_q;
	logic [KW-1:0]        sh_q;
	logic [VW-1:0]        val_q;
	logic                 ins_q;
	logic [HASH_BITS-1:0] h_q;
	logic [HASH_BITS-1:0] hx;
	logic [2*HASH_BITS:0] prod;
	logic [IW-1:0]        quo_q;
	logic [RCW-1:0]       rcnt_q;
	logic [IW-1:0]        rem_next;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        n_q;
	logic [IW-1:0]        clr_q;
	logic                 we;
	logic [IW-1:0]        waddr;
	logic [WW-1:0]        wdata;
	logic [WW-1:0]        rdata;
	logic [VW-1:0]        rd_val;
	logic                 done_q;
	rsp_t                 rsp_q;

	// The key ends at its first zero byte; later bytes are cleared.
	always_comb begin
		logic alive;
		alive = 1'b1;
		nk_d  = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			alive = alive && (req.key_bytes[8*i +: 8] != 8'd0);
			nk_d[8*i +: 8] = alive ? req.key_bytes[8*i +: 8] : 8'd0;
		end
	end

	assign hx = h_q ^ HASH_BITS'(sh_q[7:0]);

	// For other depths the home slot comes from a reciprocal multiply: the quotient
	// first, then the remainder from the low bits of the hash and of quotient times depth.
	assign prod     = (2*HASH_BITS+1)'(h_q) * (2*HASH_BITS+1)'(RECIP);
	assign rem_next = h_q[IW-1:0] - quo_q * DEPTH_LO;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nk_q  <= nk_d;
			sh_q  <= nk_d;
			val_q <= req.handler_id[VW-1:0];
			ins_q <= (req.req_type == REQ_INSERT);
			h_q   <= FNV_BASIS;
		end
		if (cmd.hash_step) begin
			h_q  <= hx * FNV_PRIME;
			sh_q <= sh_q >> 8;
		end
		if (cmd.red_load) begin
			rcnt_q <= '0;
			n_q    <= '0;
			idx_q  <= IS_POW2 ? h_q[IW-1:0] : '0;
		end
		if (cmd.red_step) begin
			rcnt_q <= rcnt_q + 1'b1;
			if (rcnt_q == '0) begin
				quo_q <= prod[HASH_BITS+IW +: IW];
			end else begin
				idx_q <= rem_next;
			end
		end
		if (cmd.advance) begin
			idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
			n_q   <= n_q + 1'b1;
		end
		if (cmd.rsp) begin
			rsp_q.status      <= cmd.code;
			rsp_q.hit         <= (cmd.code == ST_HIT) || (cmd.code == ST_UPDATED);
			rsp_q.handler_out <= (cmd.code == ST_HIT) ? HANDLER_BITS'(rd_val) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.rsp;
			if (cmd.clr) begin
				clr_q <= (clr_q == LAST_SLOT) ? '0 : clr_q + 1'b1;
			end
		end
	end

	assign we    = cmd.clr || cmd.wr;
	assign waddr = cmd.clr ? clr_q : idx_q;
	assign wdata = cmd.clr ? '0 : {1'b1, nk_q, val_q};

	flph_ram #(
		.WIDTH(WW),
		.DEPTH(TABLE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign rd_val = rdata[VW-1:0];

	assign sts.clr_last   = (clr_q == LAST_SLOT);
	assign sts.null_req   = (req.req_type == REQ_INSERT) && (req.handler_id[VW-1:0] == '0);
	assign sts.is_ins     = ins_q;
	assign sts.hash_end   = (sh_q[7:0] == 8'd0);
	assign sts.red_done   = IS_POW2 || (rcnt_q == RCW'(2));
	assign sts.used       = rdata[WW-1];
	assign sts.match      = (rdata[VW +: KW] == nk_q);
	assign sts.probe_last = (n_q == LAST_SLOT);

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule
`default_nettype wire

FILE: sv/fnv1a_linear_probe_hash_table.sv
// After start is taken the block hashes the key, one FNV-1a byte per cycle, then reduces
// the hash to a home slot and probes slots, each by a slot RAM read, then a compare; a
// table depth that is not a power of two adds a quotient step and a remainder step.
// An insert with a null handler answers in the next cycle. One request at a time; busy
// falls as done rises. Reset runs a clearing pass over all TABLE_DEPTH slots with busy high.
`default_nettype none
module fnv1a_linear_probe_hash_table
	import flph_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BYTES   = KEY_BYTES_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	flph_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.sts   (sts)
	);

	flph_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BYTES  (KEY_BYTES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp),
		.done  (done)
	);

endmodule
`default_nettype wire

FILE: sv/flph_checker.sv
`default_nettype none
`include "fnv1a_linear_probe_hash_table_assert.svh"
module flph_checker
	import flph_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	// A taken request either keeps the block busy or answers at once.
	`FLPH_ASSERT_NXT(a_accept_progress, clk, arst_n, start && !busy, busy || done)

	// The block is free again whenever it answers.
	`FLPH_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy)

	// The hit flag agrees with the status code.
	`FLPH_ASSERT_IMP(a_hit_status, clk, arst_n, done, rsp.hit == ((rsp.status == ST_HIT) || (rsp.status == ST_UPDATED)))

	// Only a lookup hit carries a handler.
	`FLPH_ASSERT_IMP(a_handler_zero, clk, arst_n, done && (rsp.status != ST_HIT), rsp.handler_out == '0)

endmodule

bind fnv1a_linear_probe_hash_table flph_checker u_flph_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
`default_nettype wire

FILE: dv/flph_result_check.sv
module flph_result_check
	import flph_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire req_t req,
	input  wire logic done,
	input  wire rsp_t rsp,
	output int        mismatches,
	output int        outstanding,
	output logic [5:0][15:0] tally
);

	logic [KEY_FIELD_BITS-1:0] slot_key [TABLE_DEPTH_DEF];
	logic [HANDLER_BITS-1:0]   slot_val [TABLE_DEPTH_DEF];
	bit                        slot_taken [TABLE_DEPTH_DEF];
	rsp_t                      awaited_rsp [$];
	int                        bad_count;
	logic [5:0][15:0]          status_seen;

	function automatic rsp_t apply_request(req_t r);
		logic [HASH_BITS-1:0]      h;
		logic [KEY_FIELD_BITS-1:0] k;
		logic [HANDLER_BITS-1:0]   v;
		int                        i;
		int                        idx;
		bit                        stop;
		rsp_t                      o;
		k = '0;
		h = FNV_BASIS;
		stop = 1'b0;
		for (i = 0; i < KEY_BYTES_DEF; i++) begin
			if (!stop) begin
				if (r.key_bytes[8*i +: 8] == 8'h00) begin
					stop = 1'b1;
				end else begin
					k[8*i +: 8] = r.key_bytes[8*i +: 8];
					h = (h ^ {24'h0, r.key_bytes[8*i +: 8]}) * FNV_PRIME;
				end
			end
		end
		v = r.handler_id;
		o = '0;
		idx = int'(h % TABLE_DEPTH_DEF);
		if (r.req_type == REQ_INSERT && v == '0) begin
			o.status = ST_NULL;
		end else begin
			o.status = (r.req_type == REQ_INSERT) ? ST_FULL : ST_MISS;
			stop = 1'b0;
			for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
				if (!stop) begin
					if (!slot_taken[idx]) begin
						if (r.req_type == REQ_INSERT) begin
							slot_taken[idx] = 1'b1;
							slot_key[idx] = k;
							slot_val[idx] = v;
							o.status = ST_INSERTED;
						end
						stop = 1'b1;
					end else if (slot_key[idx] == k) begin
						o.hit = 1'b1;
						if (r.req_type == REQ_INSERT) begin
							slot_val[idx] = v;
							o.status = ST_UPDATED;
						end else begin
							o.handler_out = slot_val[idx];
							o.status = ST_HIT;
						end
						stop = 1'b1;
					end else begin
						idx = (idx + 1) % TABLE_DEPTH_DEF;
					end
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp;
		int   i;
		if (!arst_n) begin
			for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
				slot_taken[i] = 1'b0;
			end
			awaited_rsp.delete();
			bad_count = 0;
			status_seen = '0;
			mismatches <= 0;
			outstanding <= 0;
			tally <= '0;
		end else begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					bad_count++;
					if (bad_count <= 10) begin
						$display("unexpected response: hit=%0d handler=%h status=%0d",
							rsp.hit, rsp.handler_out, rsp.status);
					end
				end else begin
					exp = awaited_rsp.pop_front();
					if (rsp.hit !== exp.hit || rsp.handler_out !== exp.handler_out ||
						rsp.status !== exp.status) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("response mismatch: expected hit=%0d handler=%h status=%0d, got hit=%0d handler=%h status=%0d",
								exp.hit, exp.handler_out, exp.status,
								rsp.hit, rsp.handler_out, rsp.status);
						end
					end else begin
						status_seen[exp.status] = status_seen[exp.status] + 16'd1;
					end
				end
			end
			if (start && !busy) begin
				awaited_rsp.push_back(apply_request(req));
			end
			mismatches <= bad_count;
			outstanding <= awaited_rsp.size();
			tally <= status_seen;
		end
	end

endmodule

FILE: dv/fnv1a_linear_probe_hash_table_tb.sv
module fnv1a_linear_probe_hash_table_tb;
	import flph_pkg::*;

	localparam int N_RANDOM    = 730;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN       = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	int               fails;
	int               pending;
	logic [5:0][15:0] tally;
	int               idle_pct;
	int               cycles = 0;
	int               issued = 0;

	logic [KEY_FIELD_BITS-1:0] known_key [$];
	int                        known_len [$];

	always #5 clk = ~clk;

	fnv1a_linear_probe_hash_table dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.req,
		.done,
		.rsp
	);

	flph_result_check u_check (
		.clk,
		.arst_n,
		.start,
		.busy,
		.req,
		.done,
		.rsp,
		.mismatches(fails),
		.outstanding(pending),
		.tally(tally)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [KEY_FIELD_BITS-1:0] garble(logic [KEY_FIELD_BITS-1:0] k, int len);
		int i;
		for (i = len + 1; i < KEY_BYTES_DEF; i++) begin
			k[8*i +: 8] = 8'($urandom_range(0, 255));
		end
		return k;
	endfunction

	task automatic fresh_key(output logic [KEY_FIELD_BITS-1:0] k);
		int len;
		int i;
		len = $urandom_range(0, KEY_BYTES_DEF);
		k = '0;
		for (i = 0; i < len; i++) begin
			k[8*i +: 8] = 8'($urandom_range(1, 255));
		end
		known_key.push_back(k);
		known_len.push_back(len);
		k = garble(k, len);
	endtask

	task automatic issue(logic kind, logic [KEY_FIELD_BITS-1:0] key, logic [HANDLER_BITS-1:0] handler);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req.req_type <= kind;
		req.key_bytes <= key;
		req.handler_id <= handler;
		do @(posedge clk); while (busy);
		issued++;
	endtask

	initial begin
		logic [KEY_FIELD_BITS-1:0] k;
		logic                      kind;
		logic [HANDLER_BITS-1:0]   handler;
		int                        n;
		int                        sel;
		int                        idx;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = 0;
		known_key.push_back(64'h0);
		known_len.push_back(0);
		known_key.push_back(64'h41);
		known_len.push_back(1);
		known_key.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		known_len.push_back(8);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		issue(REQ_LOOKUP, 64'h0, 16'h0000);
		issue(REQ_INSERT, 64'h0, 16'h0000);
		issue(REQ_INSERT, 64'h0, 16'hFFFF);
		issue(REQ_LOOKUP, 64'h0, 16'h1234);
		issue(REQ_LOOKUP, 64'h00FF_FFFF_FFFF_FF00, 16'hFFFF);
		issue(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001);
		issue(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
		issue(REQ_INSERT, 64'h0000_0000_0000_0041, 16'h8000);
		issue(REQ_INSERT, 64'hDEAD_BEEF_0000_0041, 16'h7FFF);
		issue(REQ_LOOKUP, 64'h0000_0000_0000_0041, 16'hFFFF);
		issue(REQ_LOOKUP, 64'h0101_0101_0101_0101, 16'h0000);
		issue(REQ_INSERT, 64'h0101_0101_0101_0101, 16'h0000);
		issue(REQ_LOOKUP, 64'h0101_0101_0101_0101, 16'h0000);
		issue(REQ_INSERT, 64'h8080_8080_8080_8080, 16'hAAAA);
		issue(REQ_INSERT, 64'h8080_8080_8080_8080, 16'h5555);
		issue(REQ_LOOKUP, 64'h8080_8080_8080_8080, 16'h0000);
		issue(REQ_LOOKUP, 64'h007F_7F7F_7F7F_7F7F, 16'h0000);
		issue(REQ_INSERT, 64'h007F_7F7F_7F7F_7F7F, 16'hFFFF);
		issue(REQ_LOOKUP, 64'hA57F_7F7F_7F7F_7F7F, 16'h0000);
		issue(REQ_LOOKUP, 64'h007F_7F7F_7F7F_7F7F, 16'h0000);

		// Fresh inserts arrive often enough that the table fills up about midway.
		for (n = 0; n < N_RANDOM; n++) begin
			case ((n / 50) % 3)
				0: idle_pct = 0;
				1: idle_pct = 55;
				default: idle_pct = 11;
			endcase
			sel = $urandom_range(99);
			if (sel < 30) begin
				fresh_key(k);
			end else begin
				idx = $urandom_range(known_key.size() - 1);
				k = garble(known_key[idx], known_len[idx]);
			end
			kind = (sel < 15 || (sel >= 30 && sel < 60)) ? REQ_INSERT : REQ_LOOKUP;
			if (sel >= 30 && sel < 35) begin
				handler = '0;
			end else if (kind == REQ_INSERT) begin
				handler = 16'($urandom_range(1, 16'hFFFF));
			end else begin
				handler = 16'($urandom_range(0, 16'hFFFF));
			end
			issue(kind, k, handler);
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d requests issued: %0d lookup hits, %0d misses, %0d inserts, %0d updates,",
			issued, tally[ST_HIT], tally[ST_MISS], tally[ST_INSERTED], tally[ST_UPDATED]);
		$display("%0d inserts refused by a full table and %0d null-handler inserts.",
			tally[ST_FULL], tally[ST_NULL]);
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: fnv1a_linear_probe_hash_table.f
+incdir+sv
sv/flph_pkg.sv
sv/flph_ram.sv
sv/flph_ctrl.sv
sv/flph_dp.sv
sv/fnv1a_linear_probe_hash_table.sv
sv/flph_checker.sv
dv/flph_result_check.sv
dv/fnv1a_linear_probe_hash_table_tb.sv
